// ----- sv/cln_pkg.sv -----
// shared types, constants and step table for the complex linear combination unit
// no dependencies; used by cln_mul, cln_seq and complex_lincomb_with_norm_unit
package cln_pkg;

  localparam int unsigned DATA_W = 32;            // q8.24 word
  localparam int unsigned FRAC_W = 24;
  localparam int unsigned OPND_W = DATA_W + 1;    // room for a negated -2^31
  localparam int unsigned PROD_W = 2 * OPND_W;
  localparam int unsigned RND_W  = PROD_W - FRAC_W;
  localparam int unsigned SUM_W  = RND_W + 3;     // six rounded terms
  localparam int unsigned NACC_W = 63;
  localparam int unsigned TSQ_W  = 64;
  localparam int unsigned STEP_W = 4;
  localparam int unsigned MODE_W = 3;
  localparam int unsigned CIDX_W = 3;

  localparam logic [STEP_W-1:0] STEP_LIN_LAST = 4'd11;
  localparam logic [STEP_W-1:0] STEP_NRM_LAST = 4'd13;

  localparam int unsigned MODE_CONJ_A = 0;
  localparam int unsigned MODE_CONJ_B = 1;
  localparam int unsigned MODE_NORM   = 2;

  localparam logic signed [DATA_W-1:0] COEF_ONE = 32'sh0100_0000;

  typedef enum logic [CIDX_W-1:0] {
    CFG_A_RE = 3'd0,
    CFG_A_IM = 3'd1,
    CFG_B_RE = 3'd2,
    CFG_B_IM = 3'd3,
    CFG_C_RE = 3'd4,
    CFG_C_IM = 3'd5,
    CFG_MODE = 3'd6
  } cfg_idx_t;

  // where a finished product goes
  typedef enum logic [1:0] {
    DST_RE_ADD,
    DST_RE_SUB,
    DST_IM_ADD,
    DST_NORM
  } dest_t;

  typedef struct packed {
    logic  vld;
    dest_t dst;
  } mul_tag_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LIN,
    ST_LDRAIN,
    ST_SAT,
    ST_NRM,
    ST_NDRAIN,
    ST_FIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic              load;
    logic              issue;
    logic [STEP_W-1:0] step;
    logic              sat_en;
    logic              fin_en;
    logic              in_rdy;
    logic              out_vld;
  } seq_ctrl_t;

  // steps 0..11 build the complex sum, 12 and 13 square the result
  function automatic dest_t step_dest(input logic [STEP_W-1:0] s);
    dest_t d;
    case (s) inside
      4'd0, 4'd2, 4'd4: d = DST_RE_ADD;
      4'd1, 4'd3, 4'd5: d = DST_RE_SUB;
      [4'd6:4'd11]:     d = DST_IM_ADD;
      default:          d = DST_NORM;
    endcase
    return d;
  endfunction

endpackage

// ----- sv/cln_mul.sv -----
// shared signed multiplier with registered product and destination tag
// depends on cln_pkg
module cln_mul (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic signed [cln_pkg::OPND_W-1:0]  op_x,
  input  logic signed [cln_pkg::OPND_W-1:0]  op_y,
  input  cln_pkg::mul_tag_t                  tag_in,
  output logic signed [cln_pkg::PROD_W-1:0]  prod,
  output cln_pkg::mul_tag_t                  tag_out
);

  logic signed [cln_pkg::PROD_W-1:0] prod_r, prod_nxt;
  cln_pkg::mul_tag_t                 tag_r, tag_nxt;

  always_comb begin
    prod_nxt = cln_pkg::PROD_W'(op_x * op_y);
    tag_nxt  = tag_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else begin
      tag_r <= tag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign prod    = prod_r;
  assign tag_out = tag_r;

endmodule

// ----- sv/cln_seq.sv -----
// sequencer: walks one word through linear, saturate, norm, finish and output phases
// depends on cln_pkg
module cln_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                out_ready,
  output cln_pkg::seq_ctrl_t  ctrl
);

  cln_pkg::state_t                state_r, state_nxt;
  logic [cln_pkg::STEP_W-1:0]     step_r, step_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cln_pkg::ST_IDLE:   if (in_valid) state_nxt = cln_pkg::ST_LIN;
      cln_pkg::ST_LIN:    if (step_r == cln_pkg::STEP_LIN_LAST) state_nxt = cln_pkg::ST_LDRAIN;
      cln_pkg::ST_LDRAIN: state_nxt = cln_pkg::ST_SAT;
      cln_pkg::ST_SAT:    state_nxt = cln_pkg::ST_NRM;
      cln_pkg::ST_NRM:    if (step_r == cln_pkg::STEP_NRM_LAST) state_nxt = cln_pkg::ST_NDRAIN;
      cln_pkg::ST_NDRAIN: state_nxt = cln_pkg::ST_FIN;
      cln_pkg::ST_FIN:    state_nxt = cln_pkg::ST_OUT;
      cln_pkg::ST_OUT:    if (out_ready) state_nxt = cln_pkg::ST_IDLE;
      default:            state_nxt = cln_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl         = '0;
    ctrl.step    = step_r;
    ctrl.in_rdy  = (state_r == cln_pkg::ST_IDLE);
    ctrl.load    = (state_r == cln_pkg::ST_IDLE) && in_valid;
    ctrl.issue   = (state_r == cln_pkg::ST_LIN) || (state_r == cln_pkg::ST_NRM);
    ctrl.sat_en  = (state_r == cln_pkg::ST_SAT);
    ctrl.fin_en  = (state_r == cln_pkg::ST_FIN);
    ctrl.out_vld = (state_r == cln_pkg::ST_OUT);
  end

  always_comb begin
    step_nxt = step_r;
    if (ctrl.load) begin
      step_nxt = '0;
    end else if (ctrl.issue) begin
      step_nxt = step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cln_pkg::ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

// ----- sv/complex_lincomb_with_norm_unit.sv -----
// Computes r = ka*op(a) + kb*op(b) + kc*c on one complex Q8.24 element per
// word, with optional conjugation of a and b, saturation to 32 bits and an
// optional running |r|^2 (24 fraction bits, clamped at 2^63-1) that is
// reported and cleared on the word marked last. All fourteen products go
// through one shared multiplier: twelve for the complex sum and two for the
// squared norm. out_valid rises after the linear products, a drain, the
// saturate step, the norm products, a drain and the finish step; in_ready
// returns the cycle after the result is taken. Coefficients and mode are
// written through cfg_we/cfg_index/cfg_data, and the user must do so only
// while the block is idle; the block itself does not enforce this.
// depends on cln_pkg, cln_mul and cln_seq
module complex_lincomb_with_norm_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [cln_pkg::CIDX_W-1:0]         cfg_index,
  input  logic [cln_pkg::DATA_W-1:0]         cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [cln_pkg::DATA_W-1:0]  in_a_re,
  input  logic signed [cln_pkg::DATA_W-1:0]  in_a_im,
  input  logic signed [cln_pkg::DATA_W-1:0]  in_b_re,
  input  logic signed [cln_pkg::DATA_W-1:0]  in_b_im,
  input  logic signed [cln_pkg::DATA_W-1:0]  in_c_re,
  input  logic signed [cln_pkg::DATA_W-1:0]  in_c_im,
  input  logic                               in_last_elem,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [cln_pkg::DATA_W-1:0]  out_r_re,
  output logic signed [cln_pkg::DATA_W-1:0]  out_r_im,
  output logic [cln_pkg::NACC_W-1:0]         out_norm_sum,
  output logic                               out_norm_valid,
  output logic                               out_sat_flag,
  output logic                               out_last_out
);

  localparam int unsigned OW = cln_pkg::OPND_W;
  localparam int unsigned DW = cln_pkg::DATA_W;

  cln_pkg::seq_ctrl_t ctrl;

  // configuration
  logic signed [DW-1:0]           ca_re_r, ca_im_r, cb_re_r, cb_im_r, cc_re_r, cc_im_r;
  logic signed [DW-1:0]           ca_re_nxt, ca_im_nxt, cb_re_nxt, cb_im_nxt;
  logic signed [DW-1:0]           cc_re_nxt, cc_im_nxt;
  logic [cln_pkg::MODE_W-1:0]     mode_r, mode_nxt;

  // operand word, imaginary parts already conjugated
  logic signed [OW-1:0]           a_re_r, a_im_r, b_re_r, b_im_r, c_re_r, c_im_r;
  logic signed [OW-1:0]           a_re_nxt, a_im_nxt, b_re_nxt, b_im_nxt, c_re_nxt, c_im_nxt;
  logic                           last_r, last_nxt;

  // accumulation
  logic signed [cln_pkg::SUM_W-1:0]  sum_re_r, sum_im_r, sum_re_nxt, sum_im_nxt;
  logic [cln_pkg::TSQ_W-1:0]         tsq_r, tsq_nxt;
  logic signed [DW-1:0]              rr_r, ri_r, rr_nxt, ri_nxt;
  logic                              sat_r, sat_nxt;
  logic [cln_pkg::NACC_W-1:0]        nacc_r, nacc_nxt;

  // result
  logic signed [DW-1:0]              o_re_r, o_im_r, o_re_nxt, o_im_nxt;
  logic [cln_pkg::NACC_W-1:0]        o_nsum_r, o_nsum_nxt;
  logic                              o_nvld_r, o_nvld_nxt, o_sat_r, o_sat_nxt;
  logic                              o_last_r, o_last_nxt;

  // multiplier
  logic signed [OW-1:0]              mx, my;
  cln_pkg::mul_tag_t                 tag_in, tag_out;
  logic signed [cln_pkg::PROD_W-1:0] prod, prod_rnd;
  logic signed [cln_pkg::RND_W-1:0]  rnd;
  logic signed [cln_pkg::SUM_W-1:0]  rnd_ext;

  // finish stage
  logic [cln_pkg::TSQ_W:0]           tsq_rnd;
  logic [cln_pkg::TSQ_W-1:0]         nsum_wide;
  logic [cln_pkg::NACC_W-1:0]        nacc_upd;
  logic                              norm_on, norm_clamp;
  logic                              re_ovf, im_ovf;

  cln_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .ctrl      (ctrl)
  );

  // operand select for the shared multiplier
  always_comb begin
    mx = '0;
    my = '0;
    case (ctrl.step)
      4'd0:    begin mx = OW'(ca_re_r); my = a_re_r; end
      4'd1:    begin mx = OW'(ca_im_r); my = a_im_r; end
      4'd2:    begin mx = OW'(cb_re_r); my = b_re_r; end
      4'd3:    begin mx = OW'(cb_im_r); my = b_im_r; end
      4'd4:    begin mx = OW'(cc_re_r); my = c_re_r; end
      4'd5:    begin mx = OW'(cc_im_r); my = c_im_r; end
      4'd6:    begin mx = OW'(ca_re_r); my = a_im_r; end
      4'd7:    begin mx = OW'(ca_im_r); my = a_re_r; end
      4'd8:    begin mx = OW'(cb_re_r); my = b_im_r; end
      4'd9:    begin mx = OW'(cb_im_r); my = b_re_r; end
      4'd10:   begin mx = OW'(cc_re_r); my = c_im_r; end
      4'd11:   begin mx = OW'(cc_im_r); my = c_re_r; end
      4'd12:   begin mx = OW'(rr_r);    my = OW'(rr_r); end
      4'd13:   begin mx = OW'(ri_r);    my = OW'(ri_r); end
      default: begin mx = '0;           my = '0; end
    endcase
    tag_in.vld = ctrl.issue;
    tag_in.dst = cln_pkg::step_dest(ctrl.step);
  end

  cln_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .op_x    (mx),
    .op_y    (my),
    .tag_in  (tag_in),
    .prod    (prod),
    .tag_out (tag_out)
  );

  // round to nearest, ties up: add half an lsb then floor
  assign prod_rnd = prod + $signed(cln_pkg::PROD_W'(1) << (cln_pkg::FRAC_W - 1));
  assign rnd      = prod_rnd[cln_pkg::PROD_W-1:cln_pkg::FRAC_W];
  assign rnd_ext  = cln_pkg::SUM_W'(rnd);

  assign re_ovf = (sum_re_r[cln_pkg::SUM_W-1:DW-1] != '0) &&
                  (sum_re_r[cln_pkg::SUM_W-1:DW-1] != '1);
  assign im_ovf = (sum_im_r[cln_pkg::SUM_W-1:DW-1] != '0) &&
                  (sum_im_r[cln_pkg::SUM_W-1:DW-1] != '1);

  assign norm_on   = mode_r[cln_pkg::MODE_NORM];
  assign tsq_rnd   = {1'b0, tsq_r} + ((cln_pkg::TSQ_W + 1)'(1) << (cln_pkg::FRAC_W - 1));
  assign nsum_wide = {1'b0, nacc_r} +
                     cln_pkg::TSQ_W'(tsq_rnd[cln_pkg::TSQ_W:cln_pkg::FRAC_W]);
  assign norm_clamp = norm_on && nsum_wide[cln_pkg::TSQ_W-1];
  assign nacc_upd   = !norm_on ? nacc_r :
                      (norm_clamp ? '1 : nsum_wide[cln_pkg::NACC_W-1:0]);

  always_comb begin
    ca_re_nxt = ca_re_r;
    ca_im_nxt = ca_im_r;
    cb_re_nxt = cb_re_r;
    cb_im_nxt = cb_im_r;
    cc_re_nxt = cc_re_r;
    cc_im_nxt = cc_im_r;
    mode_nxt  = mode_r;
    if (cfg_we) begin
      case (cln_pkg::cfg_idx_t'(cfg_index))
        cln_pkg::CFG_A_RE: ca_re_nxt = cfg_data;
        cln_pkg::CFG_A_IM: ca_im_nxt = cfg_data;
        cln_pkg::CFG_B_RE: cb_re_nxt = cfg_data;
        cln_pkg::CFG_B_IM: cb_im_nxt = cfg_data;
        cln_pkg::CFG_C_RE: cc_re_nxt = cfg_data;
        cln_pkg::CFG_C_IM: cc_im_nxt = cfg_data;
        cln_pkg::CFG_MODE: mode_nxt  = cfg_data[cln_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    a_re_nxt = a_re_r;
    a_im_nxt = a_im_r;
    b_re_nxt = b_re_r;
    b_im_nxt = b_im_r;
    c_re_nxt = c_re_r;
    c_im_nxt = c_im_r;
    last_nxt = last_r;
    if (ctrl.load) begin
      a_re_nxt = OW'(in_a_re);
      a_im_nxt = mode_r[cln_pkg::MODE_CONJ_A] ? -OW'(in_a_im) : OW'(in_a_im);
      b_re_nxt = OW'(in_b_re);
      b_im_nxt = mode_r[cln_pkg::MODE_CONJ_B] ? -OW'(in_b_im) : OW'(in_b_im);
      c_re_nxt = OW'(in_c_re);
      c_im_nxt = OW'(in_c_im);
      last_nxt = in_last_elem;
    end
  end

  always_comb begin
    sum_re_nxt = sum_re_r;
    sum_im_nxt = sum_im_r;
    tsq_nxt    = tsq_r;
    if (ctrl.load) begin
      sum_re_nxt = '0;
      sum_im_nxt = '0;
      tsq_nxt    = '0;
    end else if (tag_out.vld) begin
      case (tag_out.dst)
        cln_pkg::DST_RE_ADD: sum_re_nxt = sum_re_r + rnd_ext;
        cln_pkg::DST_RE_SUB: sum_re_nxt = sum_re_r - rnd_ext;
        cln_pkg::DST_IM_ADD: sum_im_nxt = sum_im_r + rnd_ext;
        cln_pkg::DST_NORM:   tsq_nxt    = tsq_r + cln_pkg::TSQ_W'(prod);
        default: ;
      endcase
    end
  end

  always_comb begin
    rr_nxt  = rr_r;
    ri_nxt  = ri_r;
    sat_nxt = sat_r;
    if (ctrl.sat_en) begin
      rr_nxt  = re_ovf ? (sum_re_r[cln_pkg::SUM_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                       : sum_re_r[DW-1:0];
      ri_nxt  = im_ovf ? (sum_im_r[cln_pkg::SUM_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                       : sum_im_r[DW-1:0];
      sat_nxt = re_ovf || im_ovf;
    end
  end

  always_comb begin
    nacc_nxt   = nacc_r;
    o_re_nxt   = o_re_r;
    o_im_nxt   = o_im_r;
    o_nsum_nxt = o_nsum_r;
    o_nvld_nxt = o_nvld_r;
    o_sat_nxt  = o_sat_r;
    o_last_nxt = o_last_r;
    if (ctrl.fin_en) begin
      // the last word of a vector reports the sum when norm is on, and clears it
      nacc_nxt   = last_r ? '0 : nacc_upd;
      o_re_nxt   = rr_r;
      o_im_nxt   = ri_r;
      o_nsum_nxt = (last_r && norm_on) ? nacc_upd : '0;
      o_nvld_nxt = last_r && norm_on;
      o_sat_nxt  = sat_r || norm_clamp;
      o_last_nxt = last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ca_re_r <= cln_pkg::COEF_ONE;
      ca_im_r <= '0;
      cb_re_r <= cln_pkg::COEF_ONE;
      cb_im_r <= '0;
      cc_re_r <= '0;
      cc_im_r <= '0;
      mode_r  <= '0;
      nacc_r  <= '0;
    end else begin
      ca_re_r <= ca_re_nxt;
      ca_im_r <= ca_im_nxt;
      cb_re_r <= cb_re_nxt;
      cb_im_r <= cb_im_nxt;
      cc_re_r <= cc_re_nxt;
      cc_im_r <= cc_im_nxt;
      mode_r  <= mode_nxt;
      nacc_r  <= nacc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_re_r   <= a_re_nxt;
    a_im_r   <= a_im_nxt;
    b_re_r   <= b_re_nxt;
    b_im_r   <= b_im_nxt;
    c_re_r   <= c_re_nxt;
    c_im_r   <= c_im_nxt;
    last_r   <= last_nxt;
    sum_re_r <= sum_re_nxt;
    sum_im_r <= sum_im_nxt;
    tsq_r    <= tsq_nxt;
    rr_r     <= rr_nxt;
    ri_r     <= ri_nxt;
    sat_r    <= sat_nxt;
    o_re_r   <= o_re_nxt;
    o_im_r   <= o_im_nxt;
    o_nsum_r <= o_nsum_nxt;
    o_nvld_r <= o_nvld_nxt;
    o_sat_r  <= o_sat_nxt;
    o_last_r <= o_last_nxt;
  end

  assign in_ready       = ctrl.in_rdy;
  assign out_valid      = ctrl.out_vld;
  assign out_r_re       = o_re_r;
  assign out_r_im       = o_im_r;
  assign out_norm_sum   = o_nsum_r;
  assign out_norm_valid = o_nvld_r;
  assign out_sat_flag   = o_sat_r;
  assign out_last_out   = o_last_r;

  // the unit holds one word at a time
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (!in_ready && !out_valid))
    else $error("unit not busy after accepting a word");

  a_no_stray_product: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ready && !$past(out_valid)) |-> !tag_out.vld)
    else $error("multiplier product arrived while idle");

  a_norm_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_out) |-> (!out_norm_valid && out_norm_sum == '0))
    else $error("norm reported on a word that is not last");

  a_cleared_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.fin_en && last_r) |=> (nacc_r == '0))
    else $error("norm accumulator not cleared after last word");

endmodule

// ----- tb/lincomb_checker.sv -----
`timescale 1ns / 100ps
// result checker for complex_lincomb_with_norm_unit: follows the register writes,
// predicts one result word per accepted input word and compares them in order
// depends on cln_pkg
module lincomb_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [cln_pkg::CIDX_W-1:0]         cfg_index,
  input  logic [cln_pkg::DATA_W-1:0]         cfg_data,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic signed [cln_pkg::DATA_W-1:0]  in_a_re,
  input  logic signed [cln_pkg::DATA_W-1:0]  in_a_im,
  input  logic signed [cln_pkg::DATA_W-1:0]  in_b_re,
  input  logic signed [cln_pkg::DATA_W-1:0]  in_b_im,
  input  logic signed [cln_pkg::DATA_W-1:0]  in_c_re,
  input  logic signed [cln_pkg::DATA_W-1:0]  in_c_im,
  input  logic                               in_last_elem,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic signed [cln_pkg::DATA_W-1:0]  out_r_re,
  input  logic signed [cln_pkg::DATA_W-1:0]  out_r_im,
  input  logic [cln_pkg::NACC_W-1:0]         out_norm_sum,
  input  logic                               out_norm_valid,
  input  logic                               out_sat_flag,
  input  logic                               out_last_out,
  output int                                 mismatch_count,
  output int                                 words_in_flight
);

  typedef struct {
    logic signed [cln_pkg::DATA_W-1:0] r_re;
    logic signed [cln_pkg::DATA_W-1:0] r_im;
    logic [cln_pkg::NACC_W-1:0]        norm_sum;
    logic                              norm_valid;
    logic                              sat_flag;
    logic                              last_out;
  } lincomb_word_t;

  localparam longint    WORD_MAX = 64'sd2147483647;
  localparam longint    WORD_MIN = -64'sd2147483648;
  localparam longint    HALF_LSB = 64'sd8388608;
  localparam bit [63:0] NORM_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  logic signed [cln_pkg::DATA_W-1:0] ka_re, ka_im, kb_re, kb_im, kc_re, kc_im;
  logic [cln_pkg::MODE_W-1:0]        mode;
  logic [cln_pkg::NACC_W-1:0]        norm_total;
  lincomb_word_t                     expected_words[$];
  lincomb_word_t                     want;

  // q8.24 product rounded to nearest, ties upward
  function automatic longint round_mul(input longint x, input longint y);
    return (x * y + HALF_LSB) >>> cln_pkg::FRAC_W;
  endfunction

  function automatic longint clamp_word(input longint v, inout bit clipped);
    if (v > WORD_MAX) begin
      clipped = 1'b1;
      return WORD_MAX;
    end
    if (v < WORD_MIN) begin
      clipped = 1'b1;
      return WORD_MIN;
    end
    return v;
  endfunction

  function automatic lincomb_word_t predict_lincomb(input longint ar, ai, br, bi, cr, ci,
                                                    input logic last);
    lincomb_word_t w;
    longint        sr, si, rr, ri;
    bit [63:0]     sq, total;
    bit            clipped;
    clipped = 1'b0;
    // negation is done wide, so -2^31 becomes +2^31 exactly
    if (mode[cln_pkg::MODE_CONJ_A]) ai = -ai;
    if (mode[cln_pkg::MODE_CONJ_B]) bi = -bi;
    sr = round_mul(ka_re, ar) - round_mul(ka_im, ai)
       + round_mul(kb_re, br) - round_mul(kb_im, bi)
       + round_mul(kc_re, cr) - round_mul(kc_im, ci);
    si = round_mul(ka_re, ai) + round_mul(ka_im, ar)
       + round_mul(kb_re, bi) + round_mul(kb_im, br)
       + round_mul(kc_re, ci) + round_mul(kc_im, cr);
    rr = clamp_word(sr, clipped);
    ri = clamp_word(si, clipped);
    if (mode[cln_pkg::MODE_NORM]) begin
      sq = 64'(rr * rr) + 64'(ri * ri);
      total = {1'b0, norm_total} + ((sq + 64'd8388608) >> cln_pkg::FRAC_W);
      if (total > NORM_MAX) begin
        total = NORM_MAX;
        clipped = 1'b1;
      end
      norm_total = total[cln_pkg::NACC_W-1:0];
    end
    w.norm_sum = '0;
    w.norm_valid = 1'b0;
    if (last) begin
      if (mode[cln_pkg::MODE_NORM]) begin
        w.norm_sum = norm_total;
        w.norm_valid = 1'b1;
      end
      norm_total = '0;
    end
    w.r_re = rr[cln_pkg::DATA_W-1:0];
    w.r_im = ri[cln_pkg::DATA_W-1:0];
    w.sat_flag = clipped;
    w.last_out = last;
    return w;
  endfunction

  function automatic void check_field(input string name, input logic signed [63:0] exp_val,
                                      input logic signed [63:0] got_val);
    if (got_val !== exp_val) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, got_val);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      ka_re = cln_pkg::COEF_ONE;
      ka_im = '0;
      kb_re = cln_pkg::COEF_ONE;
      kb_im = '0;
      kc_re = '0;
      kc_im = '0;
      mode = '0;
      norm_total = '0;
      expected_words.delete();
      mismatch_count = 0;
      words_in_flight = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected: r_re %0d, r_im %0d", out_r_re, out_r_im);
          mismatch_count++;
        end else begin
          want = expected_words.pop_front();
          check_field("r_re", want.r_re, out_r_re);
          check_field("r_im", want.r_im, out_r_im);
          check_field("norm_sum", want.norm_sum, out_norm_sum);
          check_field("norm_valid", want.norm_valid, out_norm_valid);
          check_field("sat_flag", want.sat_flag, out_sat_flag);
          check_field("last_out", want.last_out, out_last_out);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          cln_pkg::CFG_A_RE: ka_re = cfg_data;
          cln_pkg::CFG_A_IM: ka_im = cfg_data;
          cln_pkg::CFG_B_RE: kb_re = cfg_data;
          cln_pkg::CFG_B_IM: kb_im = cfg_data;
          cln_pkg::CFG_C_RE: kc_re = cfg_data;
          cln_pkg::CFG_C_IM: kc_im = cfg_data;
          cln_pkg::CFG_MODE: mode = cfg_data[cln_pkg::MODE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_words.push_back(predict_lincomb(in_a_re, in_a_im, in_b_re, in_b_im,
                                                 in_c_re, in_c_im, in_last_elem));
      words_in_flight = expected_words.size();
    end
  end

endmodule

// ----- tb/complex_lincomb_with_norm_unit_test.sv -----
`timescale 1ns / 100ps
// top of the complex_lincomb_with_norm_unit test: clock, reset, register writes,
// directed and random input words, a randomly stalling sink and the verdict
// depends on cln_pkg, lincomb_checker and the unit under test
module complex_lincomb_with_norm_unit_test;

  localparam int HOLD_CYCLES   = 500;
  localparam int RANDOM_PHASES = 13;
  localparam int PHASE_WORDS   = 100;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int DRAIN_CYCLES  = 40;

  localparam logic [cln_pkg::CIDX_W-1:0] CFG_SPARE = 3'd7;   // no register behind it

  localparam logic [cln_pkg::DATA_W-1:0] W_MAX     = 32'h7FFF_FFFF;
  localparam logic [cln_pkg::DATA_W-1:0] W_MIN     = 32'h8000_0000;
  localparam logic [cln_pkg::DATA_W-1:0] W_ONE     = cln_pkg::COEF_ONE;
  localparam logic [cln_pkg::DATA_W-1:0] W_NEG_ONE = 32'hFF00_0000;
  localparam logic [cln_pkg::DATA_W-1:0] W_HALF    = 32'h0080_0000;
  localparam logic [cln_pkg::DATA_W-1:0] W_TWO     = 32'h0200_0000;
  localparam logic [cln_pkg::DATA_W-1:0] W_LSB     = 32'h0000_0001;

  localparam int MODE_PAD = cln_pkg::DATA_W - cln_pkg::MODE_W;

  logic                               clk;
  logic                               rst_n;
  logic                               cfg_we;
  logic [cln_pkg::CIDX_W-1:0]         cfg_index;
  logic [cln_pkg::DATA_W-1:0]         cfg_data;
  logic                               in_valid;
  logic                               in_ready;
  logic signed [cln_pkg::DATA_W-1:0]  in_a_re, in_a_im, in_b_re, in_b_im, in_c_re, in_c_im;
  logic                               in_last_elem;
  logic                               out_valid;
  logic                               out_ready;
  logic signed [cln_pkg::DATA_W-1:0]  out_r_re, out_r_im;
  logic [cln_pkg::NACC_W-1:0]         out_norm_sum;
  logic                               out_norm_valid, out_sat_flag, out_last_out;
  int                                 mismatch_count;
  int                                 words_in_flight;

  bit send_quiet;
  bit sink_quiet;
  bit hold_sink;

  complex_lincomb_with_norm_unit dut (.*);

  lincomb_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    for (int n = 0; n < CYCLE_LIMIT; n++) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  function automatic int draw_gap(input bit quiet);
    return quiet ? 0 : $urandom_range(0, 19);
  endfunction

  function automatic logic [cln_pkg::DATA_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return W_MAX;
      1: return W_MIN;
      2: return '0;
      3, 4: return $urandom();
      default: return int'($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
    endcase
  endfunction

  function automatic logic [cln_pkg::DATA_W-1:0] pick_coef();
    case ($urandom_range(0, 9))
      0: return W_MAX;
      1: return W_MIN;
      2: return '0;
      3: return W_ONE;
      4: return W_NEG_ONE;
      5: return $urandom();
      default: return int'($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
    endcase
  endfunction

  task automatic write_reg(input logic [cln_pkg::CIDX_W-1:0] idx,
                           input logic [cln_pkg::DATA_W-1:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // stop offering and wait for every outstanding result word
  task automatic settle();
    in_valid = 1'b0;
    while (words_in_flight != 0) @(negedge clk);
  endtask

  task automatic load_coefs(input logic [cln_pkg::DATA_W-1:0] a_re, a_im, b_re, b_im,
                            c_re, c_im, input logic [cln_pkg::MODE_W-1:0] m);
    settle();
    write_reg(cln_pkg::CFG_A_RE, a_re);
    write_reg(cln_pkg::CFG_A_IM, a_im);
    write_reg(cln_pkg::CFG_B_RE, b_re);
    write_reg(cln_pkg::CFG_B_IM, b_im);
    write_reg(cln_pkg::CFG_C_RE, c_re);
    write_reg(cln_pkg::CFG_C_IM, c_im);
    write_reg(cln_pkg::CFG_MODE, {{MODE_PAD{1'b0}}, m});
  endtask

  // valid stays high into the next word when no gap is drawn
  task automatic send_element(input logic [cln_pkg::DATA_W-1:0] ar, ai, br, bi, cr, ci,
                              input logic last);
    int gap;
    gap = draw_gap(send_quiet);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_a_re = ar;
    in_a_im = ai;
    in_b_re = br;
    in_b_im = bi;
    in_c_re = cr;
    in_c_im = ci;
    in_last_elem = last;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // result sink
  initial begin
    int stall;
    bit hold_done;
    out_ready = 1'b0;
    hold_done = 1'b0;
    while (!rst_n) @(negedge clk);
    forever begin
      if (hold_sink && !hold_done) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      stall = draw_gap(sink_quiet);
      if (!sink_quiet && $urandom_range(0, 1)) begin
        out_ready = 1'b0;
        do @(posedge clk); while (!out_valid);
        @(negedge clk);
      end
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    logic [cln_pkg::MODE_W-1:0] mode_pick;
    int                         left_in_vec;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_a_re = '0;
    in_a_im = '0;
    in_b_re = '0;
    in_b_im = '0;
    in_c_re = '0;
    in_c_im = '0;
    in_last_elem = 1'b0;
    send_quiet = 1'b0;
    sink_quiet = 1'b0;
    hold_sink = 1'b0;
    left_in_vec = 0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // reset coefficients: plain a + b
    send_element('0, '0, '0, '0, '0, '0, 1'b0);
    send_element(W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, 1'b0);
    send_element(W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, 1'b1);
    send_element(W_ONE, W_HALF, W_NEG_ONE, W_TWO, W_HALF, W_ONE, 1'b0);
    send_element(W_LSB, 32'hFFFF_FFFF, W_LSB, '0, '0, '0, 1'b1);

    // a - b + i*c, both conjugates, norm on
    load_coefs(W_ONE, '0, W_NEG_ONE, '0, '0, W_ONE, 3'b111);
    write_reg(CFG_SPARE, 32'hFFFF_FFFF);
    send_element('0, W_MIN, '0, '0, '0, '0, 1'b0);
    send_element('0, W_MIN, '0, W_MIN, '0, '0, 1'b0);
    send_element(W_MAX, W_MIN, W_MIN, W_MIN, W_MIN, W_MAX, 1'b0);
    send_element(W_ONE, W_HALF, W_HALF, W_NEG_ONE, W_TWO, 32'h0000_0003, 1'b1);

    // norm switched off and back on within one vector
    load_coefs(W_HALF, W_ONE, W_TWO, W_NEG_ONE, W_NEG_ONE, W_HALF, 3'b100);
    send_element(W_ONE, W_ONE, W_ONE, W_ONE, W_ONE, W_ONE, 1'b0);
    settle();
    write_reg(cln_pkg::CFG_MODE, '0);
    send_element(W_TWO, W_NEG_ONE, W_HALF, W_ONE, W_NEG_ONE, W_TWO, 1'b0);
    settle();
    write_reg(cln_pkg::CFG_MODE, {{MODE_PAD{1'b0}}, 3'b101});
    send_element(W_HALF, W_TWO, W_NEG_ONE, W_HALF, W_ONE, W_NEG_ONE, 1'b1);

    // extreme coefficients
    load_coefs(W_MIN, W_MAX, W_MAX, W_MIN, W_MIN, W_MIN, 3'b110);
    send_element(W_ONE, W_ONE, W_ONE, W_ONE, W_ONE, W_ONE, 1'b0);
    send_element(W_MIN, W_MIN, W_MAX, W_MAX, W_MIN, W_MAX, 1'b0);
    send_element(W_LSB, W_LSB, W_LSB, W_LSB, W_LSB, W_LSB, 1'b1);
    send_element('0, '0, '0, '0, '0, '0, 1'b1);

    // random vectors; a vector may run across a register change
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      mode_pick = cln_pkg::MODE_W'($urandom_range(0, 7));
      if ($urandom_range(0, 3) != 0) mode_pick[cln_pkg::MODE_NORM] = 1'b1;
      load_coefs(pick_coef(), pick_coef(), pick_coef(), pick_coef(), pick_coef(), pick_coef(),
                 mode_pick);
      if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE, $urandom());
      send_quiet = ($urandom_range(0, 3) == 0);
      sink_quiet = ($urandom_range(0, 3) == 0);
      if (p == 2) hold_sink = 1'b1;
      repeat (PHASE_WORDS) begin
        if (left_in_vec == 0)
          left_in_vec = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 12);
        send_element(pick_sample(), pick_sample(), pick_sample(), pick_sample(),
                     pick_sample(), pick_sample(), left_in_vec == 1);
        left_in_vec--;
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && words_in_flight == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
